[design/y2r_pkg.sv]
`default_nettype none

package y2r_pkg;

    // Conversion coefficients, scaled by 1000.
    localparam logic [11:0] COEF_LUMA = 12'd1164;
    localparam logic [11:0] COEF_RV   = 12'd1596;
    localparam logic [11:0] COEF_GV   = 12'd813;
    localparam logic [11:0] COEF_GU   = 12'd391;
    localparam logic [11:0] COEF_BU   = 12'd2018;

    localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
    localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

    // Division by 1000 is a multiplication by ceil(2^28 / 1000) and a shift.
    // The result is exact for every product magnitude up to 480000, which
    // covers the largest product of 1164 * 239.
    localparam int unsigned  RECIP_SHIFT = 28;
    localparam logic [18:0]  RECIP_MULT  = 19'd268436;

    localparam logic signed [11:0] CHANNEL_MAX = 12'sd255;

    typedef logic [18:0]        prod_t;
    typedef logic [8:0]         quot_t;
    typedef logic signed [9:0]  term_t;
    typedef logic signed [11:0] chan_sum_t;

    // Load enables of the two pipeline stages inside a term unit.
    typedef struct packed {
        logic mult;
        logic scale;
    } load_t;

endpackage

`default_nettype wire

[design/y2r_if.sv]
`default_nettype none

interface y2r_yuyv_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;

    modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                    input ready);
    modport sink   (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                    output ready);
endinterface

interface y2r_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;

    modport source (output valid, red_first, green_first, blue_first,
                    red_second, green_second, blue_second,
                    input ready);
    modport sink   (input valid, red_first, green_first, blue_first,
                    red_second, green_second, blue_second,
                    output ready);
endinterface

`default_nettype wire

[design/y2r_term.sv]
`default_nettype none

// One scaled term: coef * value / 1000, truncated toward zero.
// Stage one forms the magnitude product, stage two divides it by the scale.
module y2r_term
(
    input  wire logic                clk,
    input  wire y2r_pkg::load_t      load,
    input  wire logic [11:0]         coef,
    input  wire logic signed [8:0]   value,
    output y2r_pkg::term_t           term
);

    logic [7:0]             mag;
    y2r_pkg::prod_t         prod_next;
    y2r_pkg::prod_t         prod_reg;
    logic                   neg_reg;
    logic [37:0]            scaled;
    y2r_pkg::quot_t         quot;
    y2r_pkg::term_t         term_next;
    y2r_pkg::term_t         term_reg;

    // Working on the magnitude makes the final quotient truncate toward zero.
    always_comb
    begin
        mag       = value[8] ? 8'(-value) : value[7:0];
        prod_next = 19'(coef) * 19'(mag);
    end

    always_ff @(posedge clk)
    begin
        if (load.mult)
        begin
            prod_reg <= prod_next;
            neg_reg  <= value[8];
        end
    end

    always_comb
    begin
        scaled    = prod_reg * y2r_pkg::RECIP_MULT;
        quot      = scaled[y2r_pkg::RECIP_SHIFT +: 9];
        term_next = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    always_ff @(posedge clk)
    begin
        if (load.scale)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

`default_nettype wire

[design/yuyv_to_rgb888_converter_core.sv]
`default_nettype none

// Throughput: one word per cycle while rgb.ready does not hold the output. An
// accepted YUYV word passes three register stages (product, divide by the scale,
// sum and clamp), each with its own valid bit, and bubbles collapse.
// Reset clears the valid bits only; data registers are not reset.
module yuyv_to_rgb888_converter_core
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    y2r_yuyv_if.sink    yuyv,
    y2r_rgb_if.source   rgb
);

    logic signed [8:0]  luma0_diff;
    logic signed [8:0]  luma1_diff;
    logic signed [8:0]  du;
    logic signed [8:0]  dv;

    logic               mult_valid_reg;
    logic               mult_valid_next;
    logic               scale_valid_reg;
    logic               scale_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               mult_ready;
    logic               scale_ready;
    logic               out_ready;
    y2r_pkg::load_t     load;

    y2r_pkg::term_t     luma0_term;
    y2r_pkg::term_t     luma1_term;
    y2r_pkg::term_t     rv_term;
    y2r_pkg::term_t     gv_term;
    y2r_pkg::term_t     gu_term;
    y2r_pkg::term_t     bu_term;

    y2r_pkg::chan_sum_t red0_sum;
    y2r_pkg::chan_sum_t green0_sum;
    y2r_pkg::chan_sum_t blue0_sum;
    y2r_pkg::chan_sum_t red1_sum;
    y2r_pkg::chan_sum_t green1_sum;
    y2r_pkg::chan_sum_t blue1_sum;

    logic [7:0]         red_first_reg;
    logic [7:0]         green_first_reg;
    logic [7:0]         blue_first_reg;
    logic [7:0]         red_second_reg;
    logic [7:0]         green_second_reg;
    logic [7:0]         blue_second_reg;

    function automatic logic [7:0] clamp_channel(input y2r_pkg::chan_sum_t x);
        logic [7:0] r;
        if (x < 0)
        begin
            r = 8'd0;
        end
        else if (x > y2r_pkg::CHANNEL_MAX)
        begin
            r = 8'd255;
        end
        else
        begin
            r = x[7:0];
        end
        return r;
    endfunction

    // A stage may load when it is empty or when its contents move on.
    always_comb
    begin
        out_ready   = !out_valid_reg || rgb.ready;
        scale_ready = !scale_valid_reg || out_ready;
        mult_ready  = !mult_valid_reg || scale_ready;
        load.mult   = mult_ready;
        load.scale  = scale_ready;

        mult_valid_next  = mult_ready  ? yuyv.valid      : mult_valid_reg;
        scale_valid_next = scale_ready ? mult_valid_reg  : scale_valid_reg;
        out_valid_next   = out_ready   ? scale_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_valid_reg  <= 1'b0;
            scale_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            mult_valid_reg  <= mult_valid_next;
            scale_valid_reg <= scale_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_comb
    begin
        luma0_diff = 9'($signed({1'b0, yuyv.luma_first})  - y2r_pkg::LUMA_OFFSET);
        luma1_diff = 9'($signed({1'b0, yuyv.luma_second}) - y2r_pkg::LUMA_OFFSET);
        du         = 9'($signed({1'b0, yuyv.chroma_blue}) - y2r_pkg::CHROMA_OFFSET);
        dv         = 9'($signed({1'b0, yuyv.chroma_red})  - y2r_pkg::CHROMA_OFFSET);
    end

    y2r_term u_luma0 (.clk(clk), .load(load), .coef(y2r_pkg::COEF_LUMA),
                      .value(luma0_diff), .term(luma0_term));
    y2r_term u_luma1 (.clk(clk), .load(load), .coef(y2r_pkg::COEF_LUMA),
                      .value(luma1_diff), .term(luma1_term));
    y2r_term u_rv    (.clk(clk), .load(load), .coef(y2r_pkg::COEF_RV),
                      .value(dv), .term(rv_term));
    y2r_term u_gv    (.clk(clk), .load(load), .coef(y2r_pkg::COEF_GV),
                      .value(dv), .term(gv_term));
    y2r_term u_gu    (.clk(clk), .load(load), .coef(y2r_pkg::COEF_GU),
                      .value(du), .term(gu_term));
    y2r_term u_bu    (.clk(clk), .load(load), .coef(y2r_pkg::COEF_BU),
                      .value(du), .term(bu_term));

    always_comb
    begin
        red0_sum   = 12'(luma0_term) + 12'(rv_term);
        green0_sum = 12'(luma0_term) - 12'(gv_term) - 12'(gu_term);
        blue0_sum  = 12'(luma0_term) + 12'(bu_term);
        red1_sum   = 12'(luma1_term) + 12'(rv_term);
        green1_sum = 12'(luma1_term) - 12'(gv_term) - 12'(gu_term);
        blue1_sum  = 12'(luma1_term) + 12'(bu_term);
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            red_first_reg    <= clamp_channel(red0_sum);
            green_first_reg  <= clamp_channel(green0_sum);
            blue_first_reg   <= clamp_channel(blue0_sum);
            red_second_reg   <= clamp_channel(red1_sum);
            green_second_reg <= clamp_channel(green1_sum);
            blue_second_reg  <= clamp_channel(blue1_sum);
        end
    end

    assign yuyv.ready       = mult_ready;
    assign rgb.valid        = out_valid_reg;
    assign rgb.red_first    = red_first_reg;
    assign rgb.green_first  = green_first_reg;
    assign rgb.blue_first   = blue_first_reg;
    assign rgb.red_second   = red_second_reg;
    assign rgb.green_second = green_second_reg;
    assign rgb.blue_second  = blue_second_reg;

endmodule

`default_nettype wire

[sim/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_WORDS  = 1550;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_LIMIT  = 10;

    // Idle patterns for both sides of the handshake.
    typedef enum int {
        IDLE_RANDOM,
        IDLE_NONE,
        IDLE_SPARSE
    } idle_mode_e;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
    } rgb_pair_t;

    class rgb_scoreboard;
        localparam int K_LUMA   = 1164;
        localparam int K_RV     = 1596;
        localparam int K_GV     = 813;
        localparam int K_GU     = 391;
        localparam int K_BU     = 2018;
        localparam int K_SCALE  = 1000;
        localparam int Y_BIAS   = 16;
        localparam int C_BIAS   = 128;
        localparam int CHAN_TOP = 255;

        rgb_pair_t pending_rgb[$];
        int        error_count;

        function new();
            error_count = 0;
        endfunction

        // Signed int division in SystemVerilog truncates toward zero.
        static function int weighted(int coef, int value);
            return (coef * value) / K_SCALE;
        endfunction

        static function logic [7:0] saturate(int x);
            if (x < 0)
                return 8'd0;
            if (x > CHAN_TOP)
                return 8'(CHAN_TOP);
            return 8'(x);
        endfunction

        static function logic [23:0] pixel_rgb(logic [7:0] luma, int du, int dv);
            int base;
            int r;
            int g;
            int b;
            base = weighted(K_LUMA, int'(luma) - Y_BIAS);
            r = base + weighted(K_RV, dv);
            g = base - weighted(K_GV, dv) - weighted(K_GU, du);
            b = base + weighted(K_BU, du);
            return {saturate(r), saturate(g), saturate(b)};
        endfunction

        function void note_macropixel(logic [7:0] y0, logic [7:0] u,
                                      logic [7:0] y1, logic [7:0] v);
            int du;
            int dv;
            du = int'(u) - C_BIAS;
            dv = int'(v) - C_BIAS;
            pending_rgb.push_back({pixel_rgb(y0, du, dv), pixel_rgb(y1, du, dv)});
        endfunction

        function void check_rgb(rgb_pair_t got);
            rgb_pair_t want;
            if (pending_rgb.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected RGB word %h at %0t", got, $realtime);
                return;
            end
            want = pending_rgb.pop_front();
            if (got.red_first !== want.red_first || got.green_first !== want.green_first ||
                got.blue_first !== want.blue_first || got.red_second !== want.red_second ||
                got.green_second !== want.green_second ||
                got.blue_second !== want.blue_second) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("RGB mismatch at %0t: expected %h actual %h",
                             $realtime, want, got);
            end
        endfunction

        function int outstanding();
            return pending_rgb.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;

    y2r_yuyv_if yuyv_ch();
    y2r_rgb_if  rgb_ch();

    yuyv_to_rgb888_converter_core dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .yuyv  (yuyv_ch),
        .rgb   (rgb_ch)
    );

    rgb_scoreboard board;
    idle_mode_e    tx_mode;
    idle_mode_e    rx_mode;

    initial
    begin
        clk = 1'b0;
        cycle_count = 0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic int pick_wait(idle_mode_e mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : 0;
            default:     return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic idle_mode_e pick_mode();
        case ($urandom_range(0, 2))
            0:       return IDLE_NONE;
            1:       return IDLE_SPARSE;
            default: return IDLE_RANDOM;
        endcase
    endfunction

    // Bytes near the offsets and the rails exercise truncation and clamping.
    function automatic logic [7:0] pick_byte();
        logic [7:0] corner [10] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17,
                                    8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        case ($urandom_range(0, 3))
            0:       return corner[$urandom_range(0, 9)];
            1:       return 8'(128 + $signed($urandom_range(0, 20)) - 10);
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_macropixel(logic [7:0] y0, logic [7:0] u,
                                   logic [7:0] y1, logic [7:0] v);
        int gap;
        gap = pick_wait(tx_mode);
        repeat (gap) begin
            @(negedge clk);
            yuyv_ch.valid = 1'b0;
        end
        @(negedge clk);
        yuyv_ch.valid       = 1'b1;
        yuyv_ch.luma_first  = y0;
        yuyv_ch.chroma_blue = u;
        yuyv_ch.luma_second = y1;
        yuyv_ch.chroma_red  = v;
        do
            @(posedge clk);
        while (!yuyv_ch.ready);
        board.note_macropixel(y0, u, y1, v);
    endtask

    task automatic collect_rgb();
        int        stall;
        int        taken;
        rgb_pair_t got;
        taken = 0;
        forever begin
            if (taken % 64 == 0)
                rx_mode = pick_mode();
            stall = pick_wait(rx_mode);
            repeat (stall) begin
                @(negedge clk);
                rgb_ch.ready = 1'b0;
            end
            @(negedge clk);
            rgb_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (!rgb_ch.valid);
            got = {rgb_ch.red_first, rgb_ch.green_first, rgb_ch.blue_first,
                   rgb_ch.red_second, rgb_ch.green_second, rgb_ch.blue_second};
            board.check_rgb(got);
            taken++;
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        yuyv_ch.valid       = 1'b0;
        yuyv_ch.luma_first  = 8'd0;
        yuyv_ch.chroma_blue = 8'd0;
        yuyv_ch.luma_second = 8'd0;
        yuyv_ch.chroma_red  = 8'd0;
        rgb_ch.ready        = 1'b0;
        tx_mode             = IDLE_RANDOM;
        rx_mode             = IDLE_RANDOM;
        board               = new();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        fork
            collect_rgb();
        join_none

        // Rails, black and white points, and both clamp directions.
        send_macropixel(8'd0,   8'd0,   8'd0,   8'd0);
        send_macropixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_macropixel(8'd16,  8'd128, 8'd16,  8'd128);
        send_macropixel(8'd235, 8'd128, 8'd0,   8'd128);
        send_macropixel(8'd0,   8'd128, 8'd255, 8'd128);
        send_macropixel(8'd255, 8'd128, 8'd255, 8'd255);
        send_macropixel(8'd0,   8'd0,   8'd255, 8'd255);
        send_macropixel(8'd255, 8'd255, 8'd0,   8'd0);
        send_macropixel(8'd128, 8'd0,   8'd128, 8'd255);
        send_macropixel(8'd128, 8'd255, 8'd128, 8'd0);
        // Small chroma offsets of either sign, where truncation toward zero matters.
        send_macropixel(8'd128, 8'd127, 8'd128, 8'd127);
        send_macropixel(8'd128, 8'd129, 8'd128, 8'd129);
        send_macropixel(8'd15,  8'd127, 8'd17,  8'd129);
        send_macropixel(8'd17,  8'd126, 8'd15,  8'd125);
        send_macropixel(8'd1,   8'd1,   8'd254, 8'd254);
        // Green takes the V term with a minus sign.
        send_macropixel(8'd100, 8'd128, 8'd100, 8'd240);
        send_macropixel(8'd100, 8'd128, 8'd100, 8'd16);
        send_macropixel(8'd100, 8'd240, 8'd100, 8'd128);
        send_macropixel(8'hAA,  8'h55,  8'h55,  8'hAA);
        send_macropixel(8'h55,  8'hAA,  8'hAA,  8'h55);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 64 == 0)
                tx_mode = pick_mode();
            send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte());
        end
        @(negedge clk);
        yuyv_ch.valid = 1'b0;

        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire
